[rtl/rau_pkg.sv]
package rau_pkg;

	// Default width limit of a result numerator or denominator
	localparam int RAU_PART_WIDTH = 32;

	// Field and datapath widths
	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W  = PROD_W + 1;

	// Opcodes
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_ZDIV = 2'd2;

	// Decoded operands, stage 1
	typedef struct packed {
		logic              is_addsub;
		logic              is_mul;
		logic              is_div;
		logic              is_cmp;
		logic              nop;
		logic              zdiv;
		logic              sa;       // sign of a
		logic              eb;       // effective sign of b for add/subtract
		logic              na;       // a strictly negative
		logic              nb;       // b strictly negative
		logic              neg_prod; // sign of a product or quotient
		logic [DATA_W-1:0] an;
		logic [DATA_W-1:0] ad;
		logic [DATA_W-1:0] bn;
		logic [DATA_W-1:0] bd;
	} s1_t;

	// Products, stage 2
	typedef struct packed {
		logic              is_addsub;
		logic              is_mul;
		logic              is_cmp;
		logic              nop;
		logic              zdiv;
		logic              sa;
		logic              eb;
		logic              na;
		logic              nb;
		logic              neg_prod;
		logic [PROD_W-1:0] prod_a;   // an * bd
		logic [PROD_W-1:0] prod_b;   // bn * ad, or an * bn for multiply
		logic [PROD_W-1:0] prod_d;   // ad * bd, or ad * bn for divide
	} s2_t;

	// Unchecked result, stage 3
	typedef struct packed {
		logic              is_cmp;
		logic              nop;
		logic              zdiv;
		logic              neg;
		logic              lt;
		logic              eq;
		logic              gt;
		logic [SUM_W-1:0]  mag;
		logic [PROD_W-1:0] den;
	} s3_t;

	// Final result, stage 4
	typedef struct packed {
		logic              r_negative;
		logic [DATA_W-1:0] r_numerator;
		logic [DATA_W-1:0] r_denominator;
		logic [1:0]        status;
		logic              is_less;
		logic              is_equal;
		logic              is_greater;
	} res_t;

endpackage

[rtl/rau_operand_if.sv]
interface rau_operand_if import rau_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        opcode;
	logic              a_negative;
	logic [DATA_W-1:0] a_numerator;
	logic [DATA_W-1:0] a_denominator;
	logic              b_negative;
	logic [DATA_W-1:0] b_numerator;
	logic [DATA_W-1:0] b_denominator;

	modport source (
		output valid, opcode, a_negative, a_numerator, a_denominator,
			b_negative, b_numerator, b_denominator,
		input  ready
	);

	modport sink (
		input  valid, opcode, a_negative, a_numerator, a_denominator,
			b_negative, b_numerator, b_denominator,
		output ready
	);
endinterface

[rtl/rau_result_if.sv]
interface rau_result_if import rau_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              r_negative;
	logic [DATA_W-1:0] r_numerator;
	logic [DATA_W-1:0] r_denominator;
	logic [1:0]        status;
	logic              is_less;
	logic              is_equal;
	logic              is_greater;

	modport source (
		output valid, r_negative, r_numerator, r_denominator, status,
			is_less, is_equal, is_greater,
		input  ready
	);

	modport sink (
		input  valid, r_negative, r_numerator, r_denominator, status,
			is_less, is_equal, is_greater,
		output ready
	);
endinterface

[rtl/rau_decode.sv]
module rau_decode import rau_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	rau_operand_if.sink        operands,
	input  logic               ready_next,
	output logic               valid_s1,
	output s1_t                data_s1
);

	logic advance;
	s1_t  dec;

	assign advance        = !valid_s1 || ready_next;
	assign operands.ready = advance;

	// Opcode decode and zero-divide detection
	always_comb begin
		dec.is_addsub = (operands.opcode == OP_ADD) || (operands.opcode == OP_SUB);
		dec.is_mul    = (operands.opcode == OP_MUL);
		dec.is_div    = (operands.opcode == OP_DIV);
		dec.is_cmp    = (operands.opcode == OP_CMP);
		dec.nop       = (operands.opcode > OP_CMP);
		dec.zdiv      = (operands.a_denominator == '0) || (operands.b_denominator == '0) ||
			((operands.opcode == OP_DIV) && (operands.b_numerator == '0));
		dec.sa        = operands.a_negative;
		dec.eb        = (operands.opcode == OP_SUB) ? !operands.b_negative
			: operands.b_negative;
		// negative zero counts as zero in compare
		dec.na        = operands.a_negative && (operands.a_numerator != '0);
		dec.nb        = operands.b_negative && (operands.b_numerator != '0);
		dec.neg_prod  = operands.a_negative ^ operands.b_negative;
		dec.an        = operands.a_numerator;
		dec.ad        = operands.a_denominator;
		dec.bn        = operands.b_numerator;
		dec.bd        = operands.b_denominator;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= operands.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && operands.valid) begin
			data_s1 <= dec;
		end
	end

endmodule

[rtl/rau_mult.sv]
module rau_mult import rau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  s1_t  data_s1,
	output logic ready_s1,
	input  logic ready_next,
	output logic valid_s2,
	output s2_t  data_s2
);

	logic              advance;
	logic [DATA_W-1:0] opnd_b;
	logic [DATA_W-1:0] opnd_d;
	s2_t               nxt;

	assign advance  = !valid_s2 || ready_next;
	assign ready_s1 = advance;

	// Three 32x32 multipliers; operand muxing covers multiply and divide
	always_comb begin
		opnd_b = data_s1.is_mul ? data_s1.an : data_s1.ad;
		opnd_d = data_s1.is_div ? data_s1.bn : data_s1.bd;

		nxt.is_addsub = data_s1.is_addsub;
		nxt.is_mul    = data_s1.is_mul;
		nxt.is_cmp    = data_s1.is_cmp;
		nxt.nop       = data_s1.nop;
		nxt.zdiv      = data_s1.zdiv;
		nxt.sa        = data_s1.sa;
		nxt.eb        = data_s1.eb;
		nxt.na        = data_s1.na;
		nxt.nb        = data_s1.nb;
		nxt.neg_prod  = data_s1.neg_prod;
		nxt.prod_a    = PROD_W'(data_s1.an) * PROD_W'(data_s1.bd);
		nxt.prod_b    = PROD_W'(data_s1.bn) * PROD_W'(opnd_b);
		nxt.prod_d    = PROD_W'(data_s1.ad) * PROD_W'(opnd_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			data_s2 <= nxt;
		end
	end

endmodule

[rtl/rau_combine.sv]
module rau_combine import rau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s2,
	input  s2_t  data_s2,
	output logic ready_s2,
	input  logic ready_next,
	output logic valid_s3,
	output s3_t  data_s3
);

	logic              advance;
	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  diff_ab;
	logic [PROD_W-1:0] diff_ba;
	logic              a_lt_b;
	logic              a_eq_b;
	logic              same_sign;
	s3_t               nxt;

	assign advance  = !valid_s3 || ready_next;
	assign ready_s2 = advance;

	// Cross-product sum, differences and magnitude compare
	always_comb begin
		sum       = {1'b0, data_s2.prod_a} + {1'b0, data_s2.prod_b};
		diff_ab   = {1'b0, data_s2.prod_a} - {1'b0, data_s2.prod_b};
		diff_ba   = data_s2.prod_b - data_s2.prod_a;
		a_lt_b    = diff_ab[SUM_W-1];
		a_eq_b    = (data_s2.prod_a == data_s2.prod_b);
		same_sign = (data_s2.sa == data_s2.eb);

		nxt.is_cmp = data_s2.is_cmp;
		nxt.nop    = data_s2.nop;
		nxt.zdiv   = data_s2.zdiv;
		nxt.den    = data_s2.prod_d;

		// result magnitude and sign
		if (data_s2.is_addsub) begin
			if (same_sign) begin
				nxt.mag = sum;
				nxt.neg = data_s2.sa;
			end else if (!a_lt_b) begin
				nxt.mag = {1'b0, diff_ab[PROD_W-1:0]};
				nxt.neg = data_s2.sa;
			end else begin
				nxt.mag = {1'b0, diff_ba};
				nxt.neg = data_s2.eb;
			end
		end else if (data_s2.is_mul) begin
			nxt.mag = {1'b0, data_s2.prod_b};
			nxt.neg = data_s2.neg_prod;
		end else begin
			nxt.mag = {1'b0, data_s2.prod_a};
			nxt.neg = data_s2.neg_prod;
		end

		// compare flags of the signed values
		nxt.lt = 1'b0;
		nxt.eq = 1'b0;
		nxt.gt = 1'b0;
		if (data_s2.na != data_s2.nb) begin
			nxt.lt = data_s2.na;
			nxt.gt = !data_s2.na;
		end else if (a_eq_b) begin
			nxt.eq = 1'b1;
		end else begin
			nxt.gt = !a_lt_b ^ data_s2.na;
			nxt.lt = a_lt_b ^ data_s2.na;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			data_s3 <= nxt;
		end
	end

endmodule

[rtl/rau_format.sv]
module rau_format import rau_pkg::*; #(
	parameter int PART_WIDTH = RAU_PART_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s3,
	input  s3_t         data_s3,
	output logic        ready_s3,
	rau_result_if.source results
);

	logic advance;
	logic valid_s4;
	res_t result_s4;
	res_t nxt;
	logic ovf;

	assign advance  = !valid_s4 || results.ready;
	assign ready_s3 = advance;

	// Range check and final result selection
	always_comb begin
		ovf = (|data_s3.mag[SUM_W-1:PART_WIDTH]) || (|data_s3.den[PROD_W-1:PART_WIDTH]);
		nxt = '0;
		if (data_s3.nop) begin
			nxt.status = ST_OK;
		end else if (data_s3.zdiv) begin
			nxt.status = ST_ZDIV;
		end else if (data_s3.is_cmp) begin
			nxt.status     = ST_OK;
			nxt.is_less    = data_s3.lt;
			nxt.is_equal   = data_s3.eq;
			nxt.is_greater = data_s3.gt;
		end else if (ovf) begin
			nxt.status = ST_OVF;
		end else begin
			nxt.status        = ST_OK;
			nxt.r_numerator   = data_s3.mag[DATA_W-1:0];
			nxt.r_denominator = data_s3.den[DATA_W-1:0];
			// zero is always positive
			nxt.r_negative    = data_s3.neg && (data_s3.mag != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s3) begin
			result_s4 <= nxt;
		end
	end

	assign results.valid         = valid_s4;
	assign results.r_negative    = result_s4.r_negative;
	assign results.r_numerator   = result_s4.r_numerator;
	assign results.r_denominator = result_s4.r_denominator;
	assign results.status        = result_s4.status;
	assign results.is_less       = result_s4.is_less;
	assign results.is_equal      = result_s4.is_equal;
	assign results.is_greater    = result_s4.is_greater;

endmodule

[rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: add, subtract, multiply, divide and compare of two
// sign-magnitude rationals with 32-bit numerator and denominator.
// Channels: operands (sink) takes opcode and both operands; results (source)
// gives one result per operand transfer, in order, with value, status and
// compare flags. A transfer happens when valid and ready are both high.
// Four register stages (decode, multiply, add/compare, range check); the
// multiply stage holds the three 32x32 multipliers.
// Throughput: one item per cycle while results.ready stays high.
// Each stage holds its item while the next is full, so a stalled receiver
// fills the bubbles first and only then deasserts operands.ready; nothing is
// dropped or repeated. Bubbles keep operands.ready high while a result waits.
// Reset (arst_n low) empties every stage at once; no result is valid after it.
// PART_WIDTH (8..32) bounds a result numerator or denominator; beyond it the
// status reports overflow and the value is zero.
module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int PART_WIDTH = RAU_PART_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	rau_operand_if.sink   operands,
	rau_result_if.source  results
);

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic ready_s1;
	logic ready_s2;
	logic ready_s3;
	s1_t  data_s1;
	s2_t  data_s2;
	s3_t  data_s3;

	rau_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.operands   (operands),
		.ready_next (ready_s1),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	rau_mult u_mult (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.ready_s1   (ready_s1),
		.ready_next (ready_s2),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2)
	);

	rau_combine u_combine (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2),
		.ready_s2   (ready_s2),
		.ready_next (ready_s3),
		.valid_s3   (valid_s3),
		.data_s3    (data_s3)
	);

	rau_format #(
		.PART_WIDTH (PART_WIDTH)
	) u_format (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3),
		.ready_s3 (ready_s3),
		.results  (results)
	);

endmodule

[rtl/rau_checker.sv]
module rau_checker import rau_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              valid,
	input logic              ready,
	input logic              r_negative,
	input logic [DATA_W-1:0] r_numerator,
	input logic [DATA_W-1:0] r_denominator,
	input logic [1:0]        status,
	input logic              is_less,
	input logic              is_equal,
	input logic              is_greater
);

	// A held result keeps its numerator, denominator and status until transferred
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(r_numerator) && $stable(r_denominator) &&
			$stable(status))
		else $error("result changed while stalled");

	// Compare results carry exactly one flag and no value
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (is_less || is_equal || is_greater) |->
			$onehot({is_less, is_equal, is_greater}) && r_numerator == '0 &&
			r_denominator == '0 && !r_negative && status == ST_OK)
		else $error("malformed compare result");

	// Any error status zeroes value and flags
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status != ST_OK |-> r_numerator == '0 && r_denominator == '0 &&
			!r_negative && !is_less && !is_equal && !is_greater &&
			(status == ST_OVF || status == ST_ZDIV))
		else $error("error result not cleared");

	// Zero is never negative
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && r_numerator == '0 |-> !r_negative)
		else $error("negative zero result");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.valid         (results.valid),
	.ready         (results.ready),
	.r_negative    (results.r_negative),
	.r_numerator   (results.r_numerator),
	.r_denominator (results.r_denominator),
	.status        (results.status),
	.is_less       (results.is_less),
	.is_equal      (results.is_equal),
	.is_greater    (results.is_greater)
);

[verif/rau_result_checker.sv]
module rau_result_checker import rau_pkg::*; #(
	parameter int PART_WIDTH = RAU_PART_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	rau_operand_if      operands,
	rau_result_if       results,
	output int unsigned failures,
	output int unsigned pending,
	output int unsigned checked,
	output int unsigned overflow_count,
	output int unsigned zdiv_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [SUM_W-1:0] PART_MAX = (SUM_W'(1) << PART_WIDTH) - SUM_W'(1);

	// Results still owed by the block, oldest first
	res_t        owed_results [$];
	res_t        want;
	res_t        got;
	int unsigned error_count;

	assign failures = error_count;

	// Exact rational arithmetic on one operand pair, never reduced
	function automatic res_t compute_rational_result(
		input logic [2:0]        op,
		input logic              sa,
		input logic [DATA_W-1:0] an,
		input logic [DATA_W-1:0] ad,
		input logic              sb,
		input logic [DATA_W-1:0] bn,
		input logic [DATA_W-1:0] bd
	);
		res_t              r;
		logic [PROD_W-1:0] p;
		logic [PROD_W-1:0] q;
		logic [PROD_W-1:0] dd;
		logic [PROD_W-1:0] den;
		logic [SUM_W-1:0]  mag;
		logic              eb;
		logic              na;
		logic              nb;
		logic              neg;
		logic              bigger;
		r   = '0;
		p   = PROD_W'(an) * PROD_W'(bd);
		q   = PROD_W'(bn) * PROD_W'(ad);
		dd  = PROD_W'(ad) * PROD_W'(bd);
		mag = '0;
		den = '0;
		neg = 1'b0;

		// unused opcodes give an all-zero result, even with a zero denominator
		if (op > OP_CMP)
			return r;
		if (ad == '0 || bd == '0 || (op == OP_DIV && bn == '0)) begin
			r.status = ST_ZDIV;
			return r;
		end

		// compare on cross products; a zero numerator is never negative
		if (op == OP_CMP) begin
			na = sa && p != '0;
			nb = sb && q != '0;
			if (na != nb) begin
				r.is_less    = na;
				r.is_greater = !na;
			end else if (p == q) begin
				r.is_equal = 1'b1;
			end else begin
				bigger       = (p > q) ^ na;
				r.is_greater = bigger;
				r.is_less    = !bigger;
			end
			return r;
		end

		case (op)
			OP_ADD, OP_SUB: begin
				eb = (op == OP_SUB) ? !sb : sb;
				if (sa == eb) begin
					mag = SUM_W'(p) + SUM_W'(q);
					neg = sa;
				end else if (p >= q) begin
					mag = SUM_W'(p - q);
					neg = sa;
				end else begin
					mag = SUM_W'(q - p);
					neg = eb;
				end
				den = dd;
			end
			OP_MUL: begin
				mag = SUM_W'(PROD_W'(an) * PROD_W'(bn));
				den = dd;
				neg = sa ^ sb;
			end
			default: begin
				// divide: multiply by the reciprocal of b
				mag = SUM_W'(p);
				den = PROD_W'(ad) * PROD_W'(bn);
				neg = sa ^ sb;
			end
		endcase

		// range check at full width; zero comes out positive
		if (mag > PART_MAX || SUM_W'(den) > PART_MAX) begin
			r.status = ST_OVF;
		end else begin
			r.r_numerator   = mag[DATA_W-1:0];
			r.r_denominator = den[DATA_W-1:0];
			r.r_negative    = neg && mag != '0;
		end
		return r;
	endfunction

	task automatic check_field(input string field, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
				$time, field, want_v, got_v);
			error_count++;
		end
	endtask

	// Result transfers are checked before the operand transfer of the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_results.delete();
			pending <= 0;
			error_count    = 0;
			checked        = 0;
			overflow_count = 0;
			zdiv_count     = 0;
		end else begin
			if (results.valid && results.ready) begin
				got.r_negative    = results.r_negative;
				got.r_numerator   = results.r_numerator;
				got.r_denominator = results.r_denominator;
				got.status        = results.status;
				got.is_less       = results.is_less;
				got.is_equal      = results.is_equal;
				got.is_greater    = results.is_greater;
				if (owed_results.size() == 0) begin
					$display("%0t ns: result with nothing outstanding, expected none, got %p",
						$time, got);
					error_count++;
				end else begin
					want = owed_results.pop_front();
					check_field("r_negative", 64'(want.r_negative), 64'(got.r_negative));
					check_field("r_numerator", 64'(want.r_numerator),
						64'(got.r_numerator));
					check_field("r_denominator", 64'(want.r_denominator),
						64'(got.r_denominator));
					check_field("status", 64'(want.status), 64'(got.status));
					check_field("is_less", 64'(want.is_less), 64'(got.is_less));
					check_field("is_equal", 64'(want.is_equal), 64'(got.is_equal));
					check_field("is_greater", 64'(want.is_greater), 64'(got.is_greater));
					checked++;
					if (want.status == ST_OVF)
						overflow_count++;
					if (want.status == ST_ZDIV)
						zdiv_count++;
				end
			end
			if (operands.valid && operands.ready)
				owed_results.push_back(compute_rational_result(operands.opcode,
					operands.a_negative, operands.a_numerator, operands.a_denominator,
					operands.b_negative, operands.b_numerator, operands.b_denominator));
			pending <= owed_results.size();
		end
	end
endmodule

[verif/rational_arithmetic_unit_test.sv]
module rational_arithmetic_unit_test import rau_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_NOP_LO        = OP_CMP + 3'd1;
	localparam logic [2:0] OP_NOP_HI        = 3'b111;
	localparam int         ITEMS_PER_PHASE  = 460;
	localparam int         HOLD_CYCLES      = 64;
	localparam int         TAIL_CYCLES      = 8;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_requests;
	int unsigned holds_done;
	int unsigned op_count [8];
	int unsigned sent_count;

	int unsigned failures;
	int unsigned pending;
	int unsigned checked;
	int unsigned overflow_count;
	int unsigned zdiv_count;

	rau_operand_if op_if ();
	rau_result_if  res_if ();

	rational_arithmetic_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (op_if),
		.results  (res_if)
	);

	rau_result_checker #(
		.PART_WIDTH (RAU_PART_WIDTH)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.operands       (op_if),
		.results        (res_if),
		.failures       (failures),
		.pending        (pending),
		.checked        (checked),
		.overflow_count (overflow_count),
		.zdiv_count     (zdiv_count)
	);

	always #2 clk = ~clk;

	// Random numerator or denominator: zero, all-ones, small, 16-bit, 2^n, full range
	function automatic logic [DATA_W-1:0] random_part(input bit is_denominator);
		case ($urandom_range(9))
			0:       return (is_denominator && $urandom_range(3) != 0) ? 32'd1 : 32'd0;
			1:       return '1;
			2:       return $urandom_range(16);
			3, 4, 5: return $urandom_range(32'hFFFF);
			6:       return $urandom_range(255);
			7:       return 32'd1 << $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	// Mostly defined opcodes, now and then any 3-bit code
	function automatic logic [2:0] random_opcode();
		logic [2:0] defined_ops [5];
		defined_ops = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP};
		if ($urandom_range(99) < 90)
			return defined_ops[$urandom_range(4)];
		return 3'($urandom);
	endfunction

	// One operand transfer, with a random lead-in gap
	task automatic send_operands(
		input logic [2:0]        op,
		input logic              sa,
		input logic [DATA_W-1:0] an,
		input logic [DATA_W-1:0] ad,
		input logic              sb,
		input logic [DATA_W-1:0] bn,
		input logic [DATA_W-1:0] bd
	);
		while ($urandom_range(99) < send_idle_pct) begin
			op_if.valid <= 1'b0;
			@(posedge clk);
		end
		op_if.valid         <= 1'b1;
		op_if.opcode        <= op;
		op_if.a_negative    <= sa;
		op_if.a_numerator   <= an;
		op_if.a_denominator <= ad;
		op_if.b_negative    <= sb;
		op_if.b_numerator   <= bn;
		op_if.b_denominator <= bd;
		@(posedge clk);
		while (!op_if.ready)
			@(posedge clk);
		op_count[op]++;
		sent_count++;
	endtask

	// Stop offering and wait for every owed result
	task automatic drain_results();
		op_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Receiver: random backpressure, plus long holds on request
	initial begin
		res_if.ready <= 1'b0;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			if (holds_done != hold_requests) begin
				holds_done++;
				for (int i = 0; i < HOLD_CYCLES; i++) begin
					res_if.ready <= 1'b0;
					@(posedge clk);
				end
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
				@(posedge clk);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int unsigned unused_ops;
		op_if.valid         <= 1'b0;
		op_if.opcode        <= OP_ADD;
		op_if.a_negative    <= 1'b0;
		op_if.a_numerator   <= '0;
		op_if.a_denominator <= '0;
		op_if.b_negative    <= 1'b0;
		op_if.b_numerator   <= '0;
		op_if.b_denominator <= '0;
		send_idle_pct = 32;
		recv_idle_pct = 55;
		hold_requests = 0;
		sent_count    = 0;
		unused_ops    = 0;
		foreach (op_count[k])
			op_count[k] = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every opcode, field extremes and the corner cases
		send_operands(OP_ADD, 1'b0, 32'd1, 32'd2, 1'b0, 32'd1, 32'd3);
		send_operands(OP_SUB, 1'b0, 32'd1, 32'd2, 1'b0, 32'd1, 32'd3);
		send_operands(OP_SUB, 1'b1, 32'd3, 32'd4, 1'b1, 32'd3, 32'd4);   // zero, positive
		send_operands(OP_SUB, 1'b0, 32'd0, 32'd1, 1'b0, 32'd5, 32'd1);   // b larger
		send_operands(OP_MUL, 1'b1, 32'd2, 32'd3, 1'b0, 32'd5, 32'd7);
		send_operands(OP_DIV, 1'b0, 32'd2, 32'd3, 1'b1, 32'd5, 32'd7);
		send_operands(OP_CMP, 1'b1, 32'd0, 32'd3, 1'b0, 32'd0, 32'd5);   // negative zero
		send_operands(OP_CMP, 1'b1, 32'd1, 32'd2, 1'b1, 32'd1, 32'd3);
		send_operands(OP_CMP, 1'b0, '1, 32'd1, 1'b0, 32'hFFFF_FFFE, 32'd1);
		send_operands(OP_CMP, 1'b1, '1, '1, 1'b0, '1, '1);
		send_operands(OP_ADD, 1'b0, '1, '1, 1'b0, '1, '1);
		send_operands(OP_ADD, 1'b0, 32'h8000_0000, 32'd1, 1'b0, 32'h8000_0000, 32'd1);
		send_operands(OP_ADD, 1'b1, 32'h7FFF_FFFF, 32'd1, 1'b1, 32'h8000_0000, 32'd1);
		send_operands(OP_MUL, 1'b0, '1, 32'd1, 1'b0, 32'd1, 32'd1);
		send_operands(OP_MUL, 1'b0, 32'h1_0000, 32'd1, 1'b0, 32'h1_0000, 32'd1);
		send_operands(OP_ADD, 1'b0, 32'd1, 32'h1_0000, 1'b0, 32'd1, 32'h1_0000);
		send_operands(OP_DIV, 1'b0, 32'd1, 32'h1_0000, 1'b0, 32'h1_0000, 32'd1);
		send_operands(OP_DIV, 1'b0, 32'd5, 32'd3, 1'b0, 32'd0, 32'd7);   // divide by zero
		send_operands(OP_ADD, 1'b0, 32'd1, 32'd0, 1'b0, 32'd1, 32'd1);
		send_operands(OP_CMP, 1'b0, 32'd1, 32'd1, 1'b0, 32'd1, 32'd0);
		send_operands(OP_MUL, 1'b0, 32'd0, '1, 1'b1, '1, '1);
		send_operands(OP_SUB, 1'b0, '1, '1, 1'b1, '1, '1);
		send_operands(OP_NOP_LO, 1'b1, 32'd9, 32'd4, 1'b1, 32'd2, 32'd3);
		send_operands(OP_NOP_HI - 3'd1, 1'b0, '1, '1, 1'b1, '1, '1);
		send_operands(OP_NOP_HI, 1'b1, 32'd1, 32'd0, 1'b0, 32'd0, 32'd0);
		drain_results();

		// random phases with different idling on each side
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 32;
					recv_idle_pct = 55;
				end
				1: begin
					send_idle_pct = 55;
					recv_idle_pct = 32;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// long receiver hold while operands keep coming
				if (phase == 2 && i == ITEMS_PER_PHASE / 4)
					hold_requests++;
				send_operands(random_opcode(), 1'($urandom), random_part(1'b0),
					random_part(1'b1), 1'($urandom), random_part(1'b0), random_part(1'b1));
			end
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		for (int k = OP_NOP_LO; k <= OP_NOP_HI; k++)
			unused_ops += op_count[k];
		$display("Sent %0d operand pairs: add %0d, sub %0d, mul %0d, div %0d, cmp %0d, unused %0d",
			sent_count, op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL],
			op_count[OP_DIV], op_count[OP_CMP], unused_ops);
		$display("Checked %0d results (%0d overflow, %0d zero divide) across three idle mixes",
			checked, overflow_count, zdiv_count);
		if (failures == 0) begin
			$display("[rational_arithmetic_unit] OK");
		end else begin
			$display("[rational_arithmetic_unit] ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("[rational_arithmetic_unit] ERROR");
		$finish;
	end
endmodule

[sim.f]
rtl/rau_pkg.sv
rtl/rau_operand_if.sv
rtl/rau_result_if.sv
rtl/rau_decode.sv
rtl/rau_mult.sv
rtl/rau_combine.sv
rtl/rau_format.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
verif/rau_result_checker.sv
verif/rational_arithmetic_unit_test.sv
